// ===== sv/mkh_pkg.sv =====
`timescale 1ns / 1ps
// mkh_pkg: shared types and constants of the multiply-xor map key hash
// no dependencies; used by mkh_front, mkh_back and the top level

package mkh_pkg;

  localparam logic [63:0] HASH_M0 = 64'd33054211828000289;
  localparam logic [63:0] HASH_M1 = 64'd23344194077549503;

  // item queue between front and back
  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = IQ_AW + 1;

  // result queue in the back part
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = OQ_AW + 1;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_F32  = 2'd1,
    FUNC_F64  = 2'd2
  } func_t;

  // classified item: x = (use_seed ? base : running hash) ^ mix,
  // new hash = mul ? x * M1 : (use_seed ? base : running hash)
  typedef struct packed {
    logic        use_seed;
    logic [63:0] base;
    logic [63:0] mix;
    logic        mul;
    logic        last;
  } item_t;

endpackage

// ===== sv/mkh_front.sv =====
`timescale 1ns / 1ps
// mkh_front: accepts key beats, classifies them and holds them in a short queue
// depends on mkh_pkg

module mkh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic               in_first,
  input  logic [63:0]        in_seed,
  input  logic [63:0]        in_key_data,
  input  logic               in_has_data,
  input  logic [63:0]        in_nan_random,
  input  logic               in_last,
  output logic               head_valid,
  output mkh_pkg::item_t     head_item,
  input  logic               head_take
);
  import mkh_pkg::*;

  item_t             cls;
  logic [63:0]       v32;
  logic [63:0]       v64;
  logic              accept;
  item_t             mem_r [IQ_DEPTH];
  logic [IQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [IQ_CW-1:0]  count_r, count_nxt;

  // float word: zeros to 0, nan to the random value, else raw bits
  always_comb begin
    if (in_key_data[30:0] == 31'd0) begin
      v32 = 64'd0;
    end else if ((&in_key_data[30:23]) && (|in_key_data[22:0])) begin
      v32 = in_nan_random;
    end else begin
      v32 = {32'd0, in_key_data[31:0]};
    end
    if (in_key_data[62:0] == 63'd0) begin
      v64 = 64'd0;
    end else if ((&in_key_data[62:52]) && (|in_key_data[51:0])) begin
      v64 = in_nan_random;
    end else begin
      v64 = in_key_data;
    end
  end

  always_comb begin
    cls.last = in_last;
    case (func_t'(in_func))
      FUNC_BYTE: begin
        cls.use_seed = in_first;
        cls.base     = HASH_M0 ^ in_seed;
        cls.mix      = {56'd0, in_key_data[7:0]};
        cls.mul      = in_has_data;
      end
      FUNC_F32: begin
        cls.use_seed = in_first;
        cls.base     = in_seed;
        cls.mix      = v32 ^ HASH_M0;
        cls.mul      = 1'b1;
      end
      FUNC_F64: begin
        cls.use_seed = in_first;
        cls.base     = in_seed;
        cls.mix      = v64 ^ HASH_M0;
        cls.mul      = 1'b1;
      end
      default: begin
        // unused code leaves the running hash alone
        cls.use_seed = 1'b0;
        cls.base     = in_seed;
        cls.mix      = 64'd0;
        cls.mul      = 1'b0;
      end
    endcase
  end

  assign in_full    = (count_r == IQ_CW'(IQ_DEPTH));
  assign accept     = in_push & ~in_full;
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = head_take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + IQ_CW'(accept) - IQ_CW'(head_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== sv/mkh_back.sv =====
`timescale 1ns / 1ps
// mkh_back: two-stage multiply on the running hash and the result queue
// depends on mkh_pkg

module mkh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  mkh_pkg::item_t     head_item,
  output logic               head_take,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [63:0]        out_hash_value
);
  import mkh_pkg::*;

  logic [63:0]       run_hash_r, run_hash_nxt;
  logic [63:0]       h;
  logic [63:0]       x;
  logic              hazard;
  logic              room;
  logic              s1_valid_r;
  logic              s1_last_r;
  logic [63:0]       p0_r, p0_nxt;
  logic [31:0]       p1_r, p1_nxt;
  logic [31:0]       p2_r, p2_nxt;
  logic [31:0]       cross_sum;
  logic [63:0]       result;
  logic              oq_wr;
  logic              oq_rd;
  logic [63:0]       oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wr_ptr_r, oq_rd_ptr_r;
  logic [OQ_CW-1:0]  oq_count_r, oq_count_nxt;

  // issue: operand select and partial products
  assign h = head_item.use_seed ? head_item.base : run_hash_r;
  assign x = h ^ head_item.mix;

  // a beat that reads the running hash waits for the one in flight
  assign hazard = s1_valid_r & ~head_item.use_seed;
  assign room   = ({1'b0, oq_count_r} + (OQ_CW + 1)'(s1_valid_r)) < (OQ_CW + 1)'(OQ_DEPTH);
  assign head_take = head_valid & ~hazard & room;

  always_comb begin
    if (head_item.mul) begin
      p0_nxt = {32'd0, x[31:0]} * {32'd0, HASH_M1[31:0]};
      p1_nxt = x[31:0] * HASH_M1[63:32];
      p2_nxt = x[63:32] * HASH_M1[31:0];
    end else begin
      p0_nxt = h;
      p1_nxt = 32'd0;
      p2_nxt = 32'd0;
    end
  end

  // finish: sum of partials, low 64 bits
  assign cross_sum = p1_r + p2_r;
  assign result    = p0_r + {cross_sum, 32'd0};
  assign run_hash_nxt = s1_valid_r ? result : run_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      run_hash_r <= '0;
    end else begin
      s1_valid_r <= head_take;
      run_hash_r <= run_hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      s1_last_r <= head_item.last;
      p0_r      <= p0_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
    end
  end

  // result queue
  assign oq_wr          = s1_valid_r & s1_last_r;
  assign out_empty      = (oq_count_r == '0);
  assign oq_rd          = out_pop & ~out_empty;
  assign out_hash_value = oq_mem_r[oq_rd_ptr_r];
  assign oq_count_nxt   = oq_count_r + OQ_CW'(oq_wr) - OQ_CW'(oq_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_count_r  <= '0;
    end else begin
      if (oq_wr) begin
        oq_wr_ptr_r <= oq_wr_ptr_r + 1'b1;
      end
      if (oq_rd) begin
        oq_rd_ptr_r <= oq_rd_ptr_r + 1'b1;
      end
      oq_count_r <= oq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_mem_r[oq_wr_ptr_r] <= result;
    end
  end

endmodule

// ===== sv/map_key_multiply_xor_hash_core.sv =====
`timescale 1ns / 1ps
// map_key_multiply_xor_hash_core: top level of the multiply-xor map key hash
// depends on mkh_pkg, mkh_front, mkh_back
//
//   channel   direction  handshake           payload
//   in_*      input      in_push / in_full   func, first, seed, key_data,
//                                            has_data, nan_random, last
//   out_*     output     out_empty / out_pop hash_value
//
// a beat is classified on entry and waits in a four-deep queue; issue does the
// xor and three 32x32 partial products into the stage-one registers, finish
// sums them into the running hash and, on a last beat, the result queue; a beat
// that chains on the running hash waits for the one in flight (the multiply
// loop); a beat that starts a key issues right behind the one before
// synchronous active-low reset empties both queues and clears the hash to 0
// results wait in a four-deep queue; issue stalls while it could overflow,
// and the input side keeps taking beats until its own queue is full

module map_key_multiply_xor_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic        in_first,
  input  logic [63:0] in_seed,
  input  logic [63:0] in_key_data,
  input  logic        in_has_data,
  input  logic [63:0] in_nan_random,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_hash_value
);
  import mkh_pkg::*;

  // classified beat at the head of the item queue
  logic  head_valid;
  item_t head_item;
  logic  head_take;

  mkh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_first      (in_first),
    .in_seed       (in_seed),
    .in_key_data   (in_key_data),
    .in_has_data   (in_has_data),
    .in_nan_random (in_nan_random),
    .in_last       (in_last),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .head_take     (head_take)
  );

  // multiply pipeline, running hash and result queue
  mkh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .head_take      (head_take),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

endmodule
